FILE: hw/rtl/checksummed_frame_receiver_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the checksummed frame receiver
// Shared property forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef CHECKSUMMED_FRAME_RECEIVER_TOP_ASSERT_SVH
`define CHECKSUMMED_FRAME_RECEIVER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg
// Constants and types shared by the checksummed frame receiver modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cfr_pkg;

    localparam int MAX_FRAME = 64;
    localparam int ADDR_W    = $clog2(MAX_FRAME);
    localparam int CNT_W     = $clog2(MAX_FRAME + 1);
    localparam int BYTE_W    = 8;
    localparam int POS_W     = 6;
    localparam int FLEN_W    = 7;

    localparam logic [BYTE_W-1:0] MIN_FRAME   = 8'd5;
    localparam logic [BYTE_W:0]   MAX_FRAME_9 = 9'(MAX_FRAME);

    localparam logic [BYTE_W-1:0] FIRST_HDR_RESET  = 8'hAA;
    localparam logic [BYTE_W-1:0] SECOND_HDR_RESET = 8'h55;

    // Register index codes on the configuration port.
    localparam logic REG_FIRST_HDR  = 1'b0;
    localparam logic REG_SECOND_HDR = 1'b1;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } store_wr_t;

    typedef struct packed {
        logic              start;
        logic [ADDR_W-1:0] last_pos;
        logic [CNT_W-1:0]  length;
    } emit_req_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cfr_frame_store.sv
// ----------------------------------------------------------------------------
// cfr_frame_store
// Frame byte memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_frame_store (
    input  wire logic                      clk,
    input  wire cfr_pkg::store_wr_t        wr,
    input  wire logic                      rd_en,
    input  wire logic [cfr_pkg::ADDR_W-1:0] rd_addr,
    output logic [cfr_pkg::BYTE_W-1:0]     rd_data
);
    import cfr_pkg::*;

    logic [BYTE_W-1:0] mem [MAX_FRAME];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/cfr_hunter.sv
// ----------------------------------------------------------------------------
// cfr_hunter
// Header search, length check, running checksum and frame byte storage.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_hunter (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      accept,
    input  wire logic [cfr_pkg::BYTE_W-1:0] rx_byte,
    input  wire logic [cfr_pkg::BYTE_W-1:0] first_hdr,
    input  wire logic [cfr_pkg::BYTE_W-1:0] second_hdr,
    output cfr_pkg::store_wr_t             wr,
    output cfr_pkg::emit_req_t             req
);
    import cfr_pkg::*;

    typedef enum logic [2:0] {
        PH_HEAD1,
        PH_HEAD2,
        PH_LEN,
        PH_BODY,
        PH_CHECK
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [CNT_W-1:0]  taken_reg, taken_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;

    always_comb
    begin
        phase_next   = phase_reg;
        len_next     = len_reg;
        taken_next   = taken_reg;
        sum_next     = sum_reg;
        wr.en        = 1'b0;
        wr.addr      = taken_reg[ADDR_W-1:0];
        wr.data      = rx_byte;
        req.start    = 1'b0;
        req.last_pos = ADDR_W'(len_reg - CNT_W'(2));
        req.length   = len_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HEAD1:
                begin
                    if (rx_byte == first_hdr)
                    begin
                        wr.en      = 1'b1;
                        wr.addr    = '0;
                        taken_next = CNT_W'(1);
                        sum_next   = rx_byte;
                        phase_next = PH_HEAD2;
                    end
                end
                PH_HEAD2:
                begin
                    if (rx_byte == second_hdr)
                    begin
                        wr.en      = 1'b1;
                        taken_next = taken_reg + CNT_W'(1);
                        sum_next   = sum_reg + rx_byte;
                        phase_next = PH_LEN;
                    end
                    else
                    begin
                        phase_next = PH_HEAD1;
                    end
                end
                PH_LEN:
                begin
                    if (rx_byte < MIN_FRAME || {1'b0, rx_byte} > MAX_FRAME_9)
                    begin
                        phase_next = PH_HEAD1;
                    end
                    else
                    begin
                        wr.en      = 1'b1;
                        len_next   = CNT_W'(rx_byte);
                        taken_next = taken_reg + CNT_W'(1);
                        sum_next   = sum_reg + rx_byte;
                        phase_next = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    wr.en      = 1'b1;
                    taken_next = taken_reg + CNT_W'(1);
                    sum_next   = sum_reg + rx_byte;
                    // Only the checksum byte is left once taken + 1 reaches the length.
                    if (({1'b0, taken_reg} + (CNT_W+1)'(2)) >= {1'b0, len_reg})
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    phase_next = PH_HEAD1;
                    req.start  = (rx_byte == sum_reg);
                end
                default:
                begin
                    phase_next = PH_HEAD1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEAD1;
            len_reg   <= '0;
            taken_reg <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            taken_reg <= taken_next;
            sum_reg   <= sum_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/cfr_emitter.sv
// ----------------------------------------------------------------------------
// cfr_emitter
// Reads a validated frame back from the store and drives the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_emitter (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire cfr_pkg::emit_req_t         req,
    output logic                            busy,
    output logic                            rd_en,
    output logic [cfr_pkg::ADDR_W-1:0]      rd_addr,
    input  wire logic [cfr_pkg::BYTE_W-1:0] rd_data,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [cfr_pkg::BYTE_W-1:0]      frame_byte,
    output logic [cfr_pkg::POS_W-1:0]       byte_position,
    output logic [cfr_pkg::FLEN_W-1:0]      frame_length,
    output logic                            last_byte
);
    import cfr_pkg::*;

    logic              busy_reg;
    logic [ADDR_W-1:0] pos_reg;
    logic [ADDR_W-1:0] last_reg;
    logic [CNT_W-1:0]  len_reg;
    logic              pend_reg;
    logic [ADDR_W-1:0] pend_pos_reg;
    logic              pend_last_reg;
    logic              ovalid_reg;
    logic [BYTE_W-1:0] obyte_reg;
    logic [POS_W-1:0]  opos_reg;
    logic [FLEN_W-1:0] olen_reg;
    logic              olast_reg;
    logic              issue;

    // One read in flight at a time; a read is issued only when the output
    // register is sure to be free when its data lands.
    assign issue   = busy_reg && !pend_reg && (!ovalid_reg || !out_stall);
    assign rd_en   = issue;
    assign rd_addr = pos_reg;
    assign busy    = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            pend_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (req.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (issue && pos_reg == last_reg)
            begin
                busy_reg <= 1'b0;
            end
            pend_reg <= issue;
            if (pend_reg)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            pos_reg  <= ADDR_W'(3);
            last_reg <= req.last_pos;
            len_reg  <= req.length;
        end
        else if (issue)
        begin
            pos_reg <= pos_reg + ADDR_W'(1);
        end
        if (issue)
        begin
            pend_pos_reg  <= pos_reg;
            pend_last_reg <= (pos_reg == last_reg);
        end
        if (pend_reg)
        begin
            obyte_reg <= rd_data;
            opos_reg  <= POS_W'(pend_pos_reg);
            olen_reg  <= FLEN_W'(len_reg);
            olast_reg <= pend_last_reg;
        end
    end

    assign out_valid     = ovalid_reg;
    assign frame_byte    = obyte_reg;
    assign byte_position = opos_reg;
    assign frame_length  = olen_reg;
    assign last_byte     = olast_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/checksummed_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// checksummed_frame_receiver_top
// Serial frame receiver with header sync, length check and 8-bit checksum.
// ----------------------------------------------------------------------------
// The block takes one received byte per item and looks for a frame of the
// form first header, second header, total length, type, payload, checksum,
// where the checksum is the 8-bit wrapping sum of every earlier byte of the
// frame. Lengths below 5 or above 64 are rejected and hunting restarts, as it
// does after a wrong second header (that byte is dropped, not retried). Every
// byte of a frame up to the checksum is written into a 64-entry frame memory
// as it arrives. When the checksum byte matches, the type and payload bytes
// are read back from that memory and sent out as one item each, with their
// position, the frame length and a mark on the last one. Each result takes
// a memory read and then a load of the output register, and only one read
// is in flight at a time. The input is held stalled while a frame is read
// out, and output stalls lengthen that. A frame that fails its checksum
// gives no item.
// The header values are set through the APB port: first header at byte
// address 0 (reset 0xAA), second header at byte address 4 (reset 0x55).
// ----------------------------------------------------------------------------
`default_nettype none

module checksummed_frame_receiver_top (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // Configuration port.
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [2:0]                 paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // Received byte channel.
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [cfr_pkg::BYTE_W-1:0] received_byte,
    // Frame byte channel.
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [cfr_pkg::BYTE_W-1:0]      frame_byte,
    output logic [cfr_pkg::POS_W-1:0]       byte_position,
    output logic [cfr_pkg::FLEN_W-1:0]      frame_length,
    output logic                            last_byte
);
    import cfr_pkg::*;

    logic [BYTE_W-1:0] first_hdr_reg;
    logic [BYTE_W-1:0] second_hdr_reg;
    logic              cfg_write;
    logic              in_accept;
    logic              emit_busy;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_data;
    store_wr_t         store_wr;
    emit_req_t         emit_req;

    // Registers sit on 4-byte boundaries; the low address bits are ignored.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_hdr_reg  <= FIRST_HDR_RESET;
            second_hdr_reg <= SECOND_HDR_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_FIRST_HDR:  first_hdr_reg  <= pwdata[BYTE_W-1:0];
                REG_SECOND_HDR: second_hdr_reg <= pwdata[BYTE_W-1:0];
                default:        first_hdr_reg  <= first_hdr_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_FIRST_HDR:  prdata = {24'd0, first_hdr_reg};
            REG_SECOND_HDR: prdata = {24'd0, second_hdr_reg};
            default:        prdata = '0;
        endcase
    end

    // The input waits while a validated frame is being read out of memory.
    // The output register decouples the two sides, so new bytes are taken
    // while the last result of a frame still waits downstream.
    assign in_stall  = emit_busy;
    assign in_accept = in_valid && !in_stall;

    cfr_hunter u_hunter (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_accept),
        .rx_byte    (received_byte),
        .first_hdr  (first_hdr_reg),
        .second_hdr (second_hdr_reg),
        .wr         (store_wr),
        .req        (emit_req)
    );

    cfr_frame_store u_store (
        .clk     (clk),
        .wr      (store_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    cfr_emitter u_emitter (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (emit_req),
        .busy          (emit_busy),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frame_byte    (frame_byte),
        .byte_position (byte_position),
        .frame_length  (frame_length),
        .last_byte     (last_byte)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/cfr_checker.sv
// ----------------------------------------------------------------------------
// cfr_checker
// Port-level checks on the frame byte channel of the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

`include "checksummed_frame_receiver_top_assert.svh"

module cfr_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic [7:0] frame_byte,
    input  wire logic [5:0] byte_position,
    input  wire logic [6:0] frame_length,
    input  wire logic       last_byte
);

    // A stalled item stays on the channel with its byte and position unchanged.
    `CFR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(frame_byte) && $stable(byte_position), "result item changed while stalled")

    // Every item lies between the type byte and the byte before the checksum.
    `CFR_ASSERT_IMPL(a_pos_range, clk, rst_n, out_valid, byte_position >= 6'd3 && 7'(byte_position) <= frame_length - 7'd2 && frame_length >= 7'd5 && frame_length <= 7'd64, "result position or length out of range")

    // The last item of a frame is the byte just before its checksum.
    `CFR_ASSERT_IMPL(a_last_pos, clk, rst_n, out_valid && last_byte, 7'(byte_position) == frame_length - 7'd2, "last mark on the wrong position")

endmodule

bind checksummed_frame_receiver_top cfr_checker u_cfr_checker (.*);

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the checksummed frame receiver.
// ----------------------------------------------------------------------------
// Received bytes are offered from a queue by a clocked driver. A bit-accurate
// frame tracker runs on every byte the block accepts and queues the frame
// bytes that a good checksum releases. A clocked monitor compares each frame
// byte the block hands out with the oldest queued one. Both sides insert
// random gaps. The header registers are changed between phases over APB and
// read back. A watchdog ends the run if no item moves for too long.
// ----------------------------------------------------------------------------

module tb_top;

    import cfr_pkg::*;

    // ------------------------------------------------------------------------
    // Run constants.
    // ------------------------------------------------------------------------
    localparam int BYTES_PER_PHASE  = 40;
    // Idle time after a drain, long enough for a 64-byte frame to empty.
    localparam int SETTLE_CYCLES    = 160;
    localparam int LONG_HOLD_CYCLES = 600;
    localparam int WATCHDOG_LIMIT   = 4000;

    // Frame tracker phases.
    typedef enum logic [2:0] {
        HUNT_HEAD1,
        HUNT_HEAD2,
        HUNT_LEN,
        HUNT_BODY,
        HUNT_CHECK
    } hunt_phase_e;

    // How often a side inserts idle cycles after an item.
    typedef enum logic [1:0] {
        GAPS_NONE,
        GAPS_SPARSE,
        GAPS_FULL
    } gap_mode_e;

    // One released frame byte, as the block should present it.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [POS_W-1:0]  pos;
        logic [FLEN_W-1:0] flen;
        logic              last;
    } frame_byte_t;

    // ------------------------------------------------------------------------
    // Block ports. Every input has a known value from time zero.
    // ------------------------------------------------------------------------
    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [2:0]        paddr         = '0;
    logic [31:0]       pwdata        = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid      = 1'b0;
    logic              in_stall;
    logic [BYTE_W-1:0] received_byte = '0;
    logic              out_valid;
    logic              out_stall     = 1'b0;
    logic [BYTE_W-1:0] frame_byte;
    logic [POS_W-1:0]  byte_position;
    logic [FLEN_W-1:0] frame_length;
    logic              last_byte;

    checksummed_frame_receiver_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .received_byte (received_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frame_byte    (frame_byte),
        .byte_position (byte_position),
        .frame_length  (frame_length),
        .last_byte     (last_byte)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Bench state.
    // ------------------------------------------------------------------------
    logic [BYTE_W-1:0] pending_rx_bytes[$];
    frame_byte_t       expected_frame_bytes[$];

    // Header values as the block should currently hold them.
    logic [BYTE_W-1:0] shadow_first_hdr  = FIRST_HDR_RESET;
    logic [BYTE_W-1:0] shadow_second_hdr = SECOND_HDR_RESET;

    // Frame tracker state, a mirror of the block's own hunt logic.
    hunt_phase_e       rx_phase        = HUNT_HEAD1;
    int                rx_expected_len = 0;
    int                rx_bytes_taken  = 0;
    logic [BYTE_W-1:0] rx_running_sum  = '0;
    logic [BYTE_W-1:0] rx_frame_store[MAX_FRAME];

    gap_mode_e tx_gap_mode = GAPS_NONE;
    gap_mode_e rx_gap_mode = GAPS_NONE;
    int        tx_gap_left = 0;
    int        rx_stall_left = 0;
    int        long_hold_left = 0;
    int        long_holds_requested = 0;
    int        long_holds_served = 0;
    int        stall_next;
    int        hold_next;
    frame_byte_t want;

    int mismatch_count     = 0;
    int bytes_queued       = 0;
    int good_frames_queued = 0;
    int rx_bytes_accepted  = 0;
    int results_checked    = 0;
    int header_settings    = 1;
    int quiet_cycles       = 0;

    // ------------------------------------------------------------------------
    // Helpers.
    // ------------------------------------------------------------------------

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what, input int got, input int wanted);
        mismatch_count++;
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, wanted);
    endtask

    function automatic int draw_gap(input gap_mode_e mode);
        case (mode)
            GAPS_FULL:   return $urandom_range(0, 16);
            GAPS_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
            default:     return 0;
        endcase
    endfunction

    // Appends one byte to the list of bytes the driver will offer.
    task automatic push_rx_byte(input logic [BYTE_W-1:0] b);
        pending_rx_bytes.push_back(b);
        bytes_queued++;
    endtask

    // Adds a frame laid out for the current headers. A negative fill makes
    // the type and payload random. With bad_sum set the checksum is off.
    task automatic queue_frame(input int flen, input bit bad_sum, input int fill);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        int                i;
        sum = '0;
        for (i = 0; i < flen - 1; i++) begin
            case (i)
                0:       b = shadow_first_hdr;
                1:       b = shadow_second_hdr;
                2:       b = BYTE_W'(flen);
                default: b = (fill < 0) ? BYTE_W'($urandom_range(0, 255)) : BYTE_W'(fill);
            endcase
            push_rx_byte(b);
            sum = sum + b;
        end
        if (bad_sum)
            sum = sum + BYTE_W'($urandom_range(1, 255));
        else
            good_frames_queued++;
        push_rx_byte(sum);
    endtask

    // Mostly short frames keep the emit bursts brief; a few reach the top.
    function automatic int pick_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            return $urandom_range(5, 12);
        else if (pick < 95)
            return $urandom_range(13, MAX_FRAME - 1);
        else
            return MAX_FRAME;
    endfunction

    // One piece of random traffic: mostly well-formed frames, the rest
    // broken frames and line noise.
    task automatic queue_random_chunk();
        int pick;
        int n;
        int i;
        pick = $urandom_range(0, 99);
        if (pick < 62) begin
            queue_frame(pick_length(), 1'b0, -1);
        end else if (pick < 70) begin
            queue_frame(pick_length(), 1'b1, -1);
        end else if (pick < 77) begin
            // Wrong second header.
            push_rx_byte(shadow_first_hdr);
            push_rx_byte(shadow_second_hdr ^ BYTE_W'($urandom_range(1, 255)));
        end else if (pick < 84) begin
            // Length out of range, either too short or too long.
            push_rx_byte(shadow_first_hdr);
            push_rx_byte(shadow_second_hdr);
            if ($urandom_range(0, 1) == 0)
                push_rx_byte(BYTE_W'($urandom_range(0, MIN_FRAME - 1)));
            else
                push_rx_byte(BYTE_W'($urandom_range(MAX_FRAME + 1, 255)));
        end else if (pick < 90) begin
            // Cut-off frame: the bytes that follow get swallowed as its body.
            push_rx_byte(shadow_first_hdr);
            push_rx_byte(shadow_second_hdr);
            push_rx_byte(BYTE_W'($urandom_range(8, 20)));
            n = $urandom_range(0, 3);
            for (i = 0; i < n; i++)
                push_rx_byte(BYTE_W'($urandom_range(0, 255)));
        end else begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++)
                push_rx_byte(BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    // Tracks one accepted byte through the hunt and queues the frame bytes
    // that a matching checksum releases.
    task automatic track_received_byte(input logic [BYTE_W-1:0] b);
        frame_byte_t fb;
        int          last_pos;
        int          p;
        case (rx_phase)
            HUNT_HEAD1: begin
                if (b == shadow_first_hdr) begin
                    rx_frame_store[0] = b;
                    rx_running_sum    = b;
                    rx_bytes_taken    = 1;
                    rx_phase          = HUNT_HEAD2;
                end
            end
            HUNT_HEAD2: begin
                // A wrong second header is dropped, not retried as a first.
                if (b == shadow_second_hdr) begin
                    rx_frame_store[ADDR_W'(rx_bytes_taken)] = b;
                    rx_running_sum = rx_running_sum + b;
                    rx_bytes_taken++;
                    rx_phase = HUNT_LEN;
                end else begin
                    rx_phase = HUNT_HEAD1;
                end
            end
            HUNT_LEN: begin
                if (b < MIN_FRAME || int'(b) > MAX_FRAME) begin
                    rx_phase = HUNT_HEAD1;
                end else begin
                    rx_expected_len = int'(b);
                    rx_frame_store[ADDR_W'(rx_bytes_taken)] = b;
                    rx_running_sum = rx_running_sum + b;
                    rx_bytes_taken++;
                    rx_phase = HUNT_BODY;
                end
            end
            HUNT_BODY: begin
                if (rx_bytes_taken < MAX_FRAME)
                    rx_frame_store[ADDR_W'(rx_bytes_taken)] = b;
                rx_running_sum = rx_running_sum + b;
                rx_bytes_taken++;
                if (rx_bytes_taken + 1 >= rx_expected_len)
                    rx_phase = HUNT_CHECK;
            end
            HUNT_CHECK: begin
                rx_phase = HUNT_HEAD1;
                if (b == rx_running_sum) begin
                    last_pos = rx_expected_len - 2;
                    for (p = 3; p <= last_pos && p < MAX_FRAME; p++) begin
                        fb.data = rx_frame_store[ADDR_W'(p)];
                        fb.pos  = POS_W'(p);
                        fb.flen = FLEN_W'(rx_expected_len);
                        fb.last = (p == last_pos);
                        expected_frame_bytes.push_back(fb);
                    end
                end
            end
            default: rx_phase = HUNT_HEAD1;
        endcase
    endtask

    // Writes one header register over APB, reads it back and updates the
    // shadow copy. The write lands at the edge that ends the access cycle.
    task automatic write_header_reg(input logic idx, input logic [BYTE_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata[BYTE_W-1:0] !== value)
            report_mismatch("header register readback", int'(prdata[BYTE_W-1:0]),
                            int'(value));
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_FIRST_HDR: shadow_first_hdr  = value;
            default:       shadow_second_hdr = value;
        endcase
    endtask

    task automatic set_headers(input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second);
        write_header_reg(REG_FIRST_HDR, first);
        write_header_reg(REG_SECOND_HDR, second);
        header_settings++;
    endtask

    // Waits until every queued byte has gone in and every released frame
    // byte has come out, then lets a failed frame finish in the block.
    task automatic drain_block();
        do
            @(negedge clk);
        while (pending_rx_bytes.size() != 0 || in_valid || expected_frame_bytes.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_random_phase(input gap_mode_e tx_mode, input gap_mode_e rx_mode);
        int start;
        @(negedge clk);
        tx_gap_mode = tx_mode;
        rx_gap_mode = rx_mode;
        start = bytes_queued;
        while (bytes_queued - start < BYTES_PER_PHASE)
            queue_random_chunk();
        drain_block();
    endtask

    // ------------------------------------------------------------------------
    // Driver: offers the pending bytes, holding each one while stalled, and
    // feeds every accepted byte to the frame tracker.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid      <= 1'b0;
            received_byte <= '0;
            tx_gap_left   <= 0;
        end
        else begin
            if (in_valid && !in_stall) begin
                track_received_byte(received_byte);
                rx_bytes_accepted++;
            end
            if (!in_valid || !in_stall) begin
                if (tx_gap_left > 0) begin
                    tx_gap_left <= tx_gap_left - 1;
                    in_valid    <= 1'b0;
                end
                else if (pending_rx_bytes.size() != 0) begin
                    in_valid      <= 1'b1;
                    received_byte <= pending_rx_bytes.pop_front();
                    tx_gap_left   <= draw_gap(tx_gap_mode);
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks every accepted frame byte against the oldest expected
    // one and drives the stall, both the per-item gaps and the long hold.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall         <= 1'b0;
            rx_stall_left     <= 0;
            long_hold_left    <= 0;
            long_holds_served <= 0;
        end
        else begin
            stall_next = (rx_stall_left > 0) ? rx_stall_left - 1 : 0;
            hold_next  = (long_hold_left > 0) ? long_hold_left - 1 : 0;
            if (out_valid && !out_stall) begin
                results_checked++;
                if (expected_frame_bytes.size() == 0) begin
                    report_mismatch("frame byte with nothing expected", int'(frame_byte), -1);
                end
                else begin
                    want = expected_frame_bytes.pop_front();
                    if (frame_byte !== want.data)
                        report_mismatch("frame_byte", int'(frame_byte), int'(want.data));
                    if (byte_position !== want.pos)
                        report_mismatch("byte_position", int'(byte_position),
                                        int'(want.pos));
                    if (frame_length !== want.flen)
                        report_mismatch("frame_length", int'(frame_length),
                                        int'(want.flen));
                    if (last_byte !== want.last)
                        report_mismatch("last_byte", int'(last_byte), int'(want.last));
                end
                stall_next = draw_gap(rx_gap_mode);
            end
            // A long hold lets the block fill up and push back on its input.
            if (long_holds_served != long_holds_requested) begin
                hold_next          = LONG_HOLD_CYCLES;
                long_holds_served <= long_holds_requested;
            end
            rx_stall_left  <= stall_next;
            long_hold_left <= hold_next;
            out_stall      <= (stall_next > 0) || (hold_next > 0);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: no item moving on either channel for too long is a hang.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[%0t] watchdog: no item moved for %0d cycles", $realtime,
                         quiet_cycles);
                $display("end of test: mismatches");
                $finish;
            end
            else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part with the reset headers and no gaps.
        @(negedge clk);
        // Shortest legal frame, type byte zero.
        queue_frame(int'(MIN_FRAME), 1'b0, 0);
        // Wrong second header: the repeated first header is dropped, so the
        // following second header byte is only noise.
        push_rx_byte(shadow_first_hdr);
        push_rx_byte(shadow_first_hdr);
        push_rx_byte(shadow_second_hdr);
        // Lengths just outside the legal range on both sides.
        push_rx_byte(shadow_first_hdr);
        push_rx_byte(shadow_second_hdr);
        push_rx_byte(BYTE_W'(MIN_FRAME - 1));
        push_rx_byte(shadow_first_hdr);
        push_rx_byte(shadow_second_hdr);
        push_rx_byte(BYTE_W'(MAX_FRAME + 1));
        // Failed checksum, then an all-ones frame whose sum wraps.
        queue_frame(6, 1'b1, -1);
        queue_frame(6, 1'b0, 255);
        drain_block();

        // Random traffic under several header settings and gap patterns.
        run_random_phase(GAPS_FULL, GAPS_FULL);
        set_headers(8'h00, 8'h00);
        run_random_phase(GAPS_SPARSE, GAPS_NONE);
        set_headers(8'hFF, 8'hFF);
        run_random_phase(GAPS_NONE, GAPS_FULL);
        set_headers(8'h00, 8'hFF);
        run_random_phase(GAPS_FULL, GAPS_SPARSE);
        set_headers(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));

        // Back-to-back frames against a long output hold, so the block
        // fills and stalls its input while the driver keeps offering.
        @(negedge clk);
        tx_gap_mode = GAPS_NONE;
        rx_gap_mode = GAPS_NONE;
        queue_frame(MAX_FRAME, 1'b0, -1);
        queue_frame(20, 1'b0, -1);
        queue_frame(30, 1'b0, -1);
        long_holds_requested++;
        drain_block();

        set_headers(FIRST_HDR_RESET, SECOND_HDR_RESET);
        run_random_phase(GAPS_SPARSE, GAPS_SPARSE);
        run_random_phase(GAPS_NONE, GAPS_NONE);

        if (expected_frame_bytes.size() != 0)
            report_mismatch("frame bytes never delivered", 0, expected_frame_bytes.size());

        $display("Covered %0d received bytes with %0d good frames, %0d frame bytes checked.",
                 rx_bytes_accepted, good_frames_queued, results_checked);
        $display("Ran %0d header settings, random gaps on both sides and one long hold.",
                 header_settings);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
